/* design/escf_pkg.sv */
// Package for the SPI command framer: action codes, frame constants and
// the header-byte helper. No dependencies.
`default_nettype none

package escf_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_REPLY = 2'd2
  } action_t;

  localparam logic [7:0] FLAG_READ  = 8'h40;
  localparam logic [7:0] FLAG_WRITE = 8'h00;
  localparam logic [7:0] WIDE_ADDR  = 8'h3f;
  localparam logic [7:0] UNLOCK_CMD = 8'h10;
  localparam logic [7:0] UNLOCK_KEY = 8'hab;
  localparam logic [7:0] LOCK_ARG   = 8'h00;

  localparam logic [1:0] BYTES_NARROW = 2'd2;
  localparam logic [1:0] BYTES_WIDE   = 2'd3;

  localparam logic [2:0] READ_LAST_IDX  = 3'd1;
  localparam logic [2:0] WRITE_LAST_IDX = 3'd5;

  // Output word kinds on tuser.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Header: bit 7 holds the parity of payload OR flag, flag in bit 6.
  function automatic logic [7:0] head_byte(input logic [7:0] payload,
                                           input logic [7:0] flag);
    head_byte = {^(payload | flag), flag[6:0]};
  endfunction

endpackage

`default_nettype wire

/* design/encoder_spi_command_framer_unit.sv */
// SPI command framer and reply decoder, top level.
// Depends on escf_pkg.
// Each item is held in the input register; each result word is registered at the output.
// Throughput: one result word per cycle while the receiver takes them; a read gives 2 words,
// a write 6 and a reply 1; an unused code gives no output. The frame index counter sets this.
// The next item is accepted in the cycle its predecessor's last word is loaded.
// Reset (rst, synchronous, active high) clears the item and output valids and the reply width.
`default_nettype none

module encoder_spi_command_framer_unit
  import escf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // address[7:0], write_data[15:8], reply_word[39:16]
  input  wire logic [1:0]  s_tuser,  // action[1:0]
  // master side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // tx_word[23:0], tx_bytes[25:24], read_data[43:26],
                                     // dev_error[44], parity_error[45], zero[47:46]
  output logic             m_tuser,  // kind
  output logic             m_tlast   // last
);

  // Held input item and its frame index.
  logic        busy;
  logic [1:0]  act;
  logic [7:0]  addr;
  logic [7:0]  wdata;
  logic [23:0] reply;
  logic [2:0]  idx;

  // Reply width kept from the last read request.
  logic        pending_wide;

  logic        s_accept;
  logic        produce;
  logic        done;

  // Result of the current frame index.
  logic        res_kind;
  logic [23:0] res_tx_word;
  logic [1:0]  res_tx_bytes;
  logic [17:0] res_read_data;
  logic        res_error;
  logic        res_parity;
  logic        res_last;
  logic        res_none;

  logic [7:0]  payload;
  logic [7:0]  flag;
  logic [7:0]  wide_head;

  assign s_accept = s_tvalid && s_tready;
  // Advance when an item is held and the output register is free or draining.
  assign produce  = busy && !res_none && (!m_tvalid || m_tready);
  // Drop unused action codes at once; otherwise finish on the last word.
  assign done     = busy && (res_none || (produce && res_last));
  assign s_tready = !busy || done;

  assign wide_head = head_byte(WIDE_ADDR, FLAG_READ);

  // Pick the payload byte and flag for this frame index.
  always_comb begin
    payload = LOCK_ARG;
    flag    = FLAG_WRITE;
    unique case (act)
      ACT_READ: begin
        flag    = FLAG_READ;
        payload = (idx == 3'd0) ? addr : WIDE_ADDR;
      end
      ACT_WRITE: begin
        flag = FLAG_WRITE;
        unique case (idx)
          3'd0:    payload = UNLOCK_CMD;
          3'd1:    payload = UNLOCK_KEY;
          3'd2:    payload = addr;
          3'd3:    payload = wdata;
          3'd4:    payload = UNLOCK_CMD;
          default: payload = LOCK_ARG;
        endcase
      end
      default: begin
        payload = LOCK_ARG;
        flag    = FLAG_WRITE;
      end
    endcase
  end

  // Build the result word.
  always_comb begin
    res_kind      = KIND_FRAME;
    res_tx_word   = '0;
    res_tx_bytes  = '0;
    res_read_data = '0;
    res_error     = 1'b0;
    res_parity    = 1'b0;
    res_last      = 1'b0;
    res_none      = 1'b0;
    unique case (act)
      ACT_READ: begin
        res_last = (idx == READ_LAST_IDX);
        if (idx != 3'd0 && addr == WIDE_ADDR) begin
          // Wide read: header, address, header again.
          res_tx_word  = {wide_head, WIDE_ADDR, wide_head};
          res_tx_bytes = BYTES_WIDE;
        end else begin
          res_tx_word  = {8'h00, head_byte(payload, flag), payload};
          res_tx_bytes = BYTES_NARROW;
        end
      end
      ACT_WRITE: begin
        res_last     = (idx == WRITE_LAST_IDX);
        res_tx_word  = {8'h00, head_byte(payload, flag), payload};
        res_tx_bytes = BYTES_NARROW;
      end
      ACT_REPLY: begin
        res_kind = KIND_REPLY;
        res_last = 1'b1;
        if (pending_wide) begin
          res_read_data = reply[21:4];
          res_error     = reply[22];
          res_parity    = ^reply;
        end else begin
          res_read_data = {4'b0000, reply[13:0]};
          res_error     = reply[14];
          res_parity    = ^reply[15:0];
        end
      end
      default: begin
        res_none = 1'b1;
      end
    endcase
  end

  // Input register and frame index.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      idx          <= '0;
      pending_wide <= 1'b0;
    end else begin
      if (s_accept) begin
        busy <= 1'b1;
        idx  <= '0;
        // Hold the reply width chosen by this read for later replies.
        if (s_tuser == ACT_READ) begin
          pending_wide <= (s_tdata[7:0] == WIDE_ADDR);
        end
      end else if (done) begin
        busy <= 1'b0;
      end else if (produce) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      act   <= s_tuser;
      addr  <= s_tdata[7:0];
      wdata <= s_tdata[15:8];
      reply <= s_tdata[39:16];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (produce) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      m_tdata <= {2'b00, res_parity, res_error, res_read_data, res_tx_bytes, res_tx_word};
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

endmodule

`default_nettype wire

/* design/escf_checker.sv */
// Port-level checker for the SPI command framer and its bind statement.
// Depends on escf_pkg and encoder_spi_command_framer_unit.
`default_nettype none

module escf_checker
  import escf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // A stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output word changed while stalled");

  // A decoded reply is always the last word of its item and carries no frame.
  a_reply: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_REPLY |-> m_tlast && m_tdata[25:0] == 26'd0)
    else $error("reply word malformed");

  // A frame has two or three bytes and no decoded fields.
  a_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_FRAME |->
      (m_tdata[25:24] == BYTES_NARROW || m_tdata[25:24] == BYTES_WIDE)
      && m_tdata[47:26] == 22'd0)
    else $error("frame word malformed");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind encoder_spi_command_framer_unit escf_checker u_escf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* bench/tb_encoder_spi_command_framer_unit.sv */
// Self-checking bench for the SPI command framer: drives request and reply words,
// predicts every frame and decoded reply, and checks the output stream.
// Depends on escf_pkg and encoder_spi_command_framer_unit.
`default_nettype none

module tb_encoder_spi_command_framer_unit;
  import escf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Action code that the block drops without output.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 140;
  localparam int IDLE_LIMIT     = 3000;  // cycles with no word moving on either side
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int HOLD_AFTER     = 40;    // result words seen before the hold-off starts
  localparam int TAIL_CYCLES    = 8;
  localparam int DRAIN_ITEM     = 100;   // random item that waits for an empty scoreboard

  // One request or reply word on the slave side.
  typedef struct {
    logic [1:0]  action;
    logic [7:0]  address;
    logic [7:0]  write_data;
    logic [23:0] reply_word;
    bit          drain;  // hold this word back until all results are in
  } cmd_item_t;

  // One result word on the master side.
  typedef struct {
    logic        kind;
    logic [23:0] tx_word;
    logic [1:0]  tx_bytes;
    logic [17:0] read_data;
    logic        dev_error;
    logic        parity_error;
    logic        last;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // address[7:0], write_data[15:8], reply_word[39:16]
  logic [1:0]  s_tuser = '0;  // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;       // tx_word[23:0], tx_bytes[25:24], read_data[43:26],
                              // dev_error[44], parity_error[45], zero[47:46]
  logic        m_tuser;       // kind
  logic        m_tlast;       // last

  cmd_item_t   cmd_queue[$];
  frame_word_t frame_scoreboard[$];

  // Reply width as the framer should hold it: set by the last read request.
  bit reply_wide = 1'b0;

  int errors = 0;
  int cmds_total = 0;
  int cmds_sent = 0;
  int n_reads = 0, n_writes = 0, n_replies = 0, n_dropped = 0, n_wide_reads = 0;
  int words_checked = 0;
  int rx_words = 0;

  encoder_spi_command_framer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Build a two-byte command: header (bit 7 the parity of payload OR flag, flag below), payload.
  function automatic logic [23:0] command_pair(logic [7:0] payload, logic [7:0] flag);
    logic [7:0] hdr;
    hdr    = flag;
    hdr[7] = ^(payload | flag);
    return {8'h00, hdr, payload};
  endfunction

  task automatic push_frame(logic [23:0] w, logic [1:0] nbytes, bit is_last);
    frame_word_t f;
    f = '{kind: KIND_FRAME, tx_word: w, tx_bytes: nbytes, read_data: '0,
          dev_error: 1'b0, parity_error: 1'b0, last: is_last};
    frame_scoreboard.push_back(f);
  endtask

  // Expand one accepted word into the frames or decoded reply it must produce.
  task automatic predict_frames(cmd_item_t it);
    logic [23:0] hw;
    logic [15:0] r;
    frame_word_t f;
    case (it.action)
      ACT_READ: begin
        push_frame(command_pair(it.address, FLAG_READ), BYTES_NARROW, 1'b0);
        if (it.address != WIDE_ADDR) begin
          push_frame(command_pair(WIDE_ADDR, FLAG_READ), BYTES_NARROW, 1'b1);
          reply_wide = 1'b0;
        end else begin
          // Wide read: header, 0x3f, header repeated.
          hw = command_pair(WIDE_ADDR, FLAG_READ);
          push_frame({hw[15:8], WIDE_ADDR, hw[15:8]}, BYTES_WIDE, 1'b1);
          reply_wide = 1'b1;
        end
      end
      ACT_WRITE: begin
        push_frame(command_pair(UNLOCK_CMD, FLAG_WRITE), BYTES_NARROW, 1'b0);
        push_frame(command_pair(UNLOCK_KEY, FLAG_WRITE), BYTES_NARROW, 1'b0);
        push_frame(command_pair(it.address, FLAG_WRITE), BYTES_NARROW, 1'b0);
        push_frame(command_pair(it.write_data, FLAG_WRITE), BYTES_NARROW, 1'b0);
        push_frame(command_pair(UNLOCK_CMD, FLAG_WRITE), BYTES_NARROW, 1'b0);
        push_frame(command_pair(LOCK_ARG, FLAG_WRITE), BYTES_NARROW, 1'b1);
      end
      ACT_REPLY: begin
        f = '{kind: KIND_REPLY, tx_word: '0, tx_bytes: '0, read_data: '0,
              dev_error: 1'b0, parity_error: 1'b0, last: 1'b1};
        if (reply_wide) begin
          f.read_data    = it.reply_word[21:4];
          f.dev_error    = it.reply_word[22];
          f.parity_error = ^it.reply_word;
        end else begin
          // Narrow decode looks at the low 16 bits only.
          r              = it.reply_word[15:0];
          f.read_data    = {4'b0000, r[13:0]};
          f.dev_error    = r[14];
          f.parity_error = ^r;
        end
        frame_scoreboard.push_back(f);
      end
      default: ;  // unused code: nothing comes out, width untouched
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued words, predict at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_item_t it;
    bit        fire;
    bit        no_idle;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        it = cmd_queue.pop_front();
        predict_frames(it);
        cmds_sent++;
        case (it.action)
          ACT_READ: begin
            n_reads++;
            if (it.address == WIDE_ADDR) n_wide_reads++;
          end
          ACT_WRITE: n_writes++;
          ACT_REPLY: n_replies++;
          default:   n_dropped++;
        endcase
      end
      // Hold the current word until it is taken; pick the next one only then.
      if (!s_tvalid || fire) begin
        no_idle = (cmds_sent >= 60 && cmds_sent < 110);
        if (cmd_queue.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (cmd_queue[0].drain && frame_scoreboard.size() != 0) begin
          s_tvalid <= 1'b0;  // wait for every outstanding result
        end else if (!no_idle && $urandom_range(99) < 8) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tuser  <= cmd_queue[0].action;
          s_tdata  <= {cmd_queue[0].reply_word, cmd_queue[0].write_data,
                       cmd_queue[0].address};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off, one stretch always ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    static int  hold_left = 0;
    static bit  hold_done = 1'b0;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) rx_words++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && rx_words >= HOLD_AFTER) begin
        // Starve the output so the block backs up and stalls its input.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (rx_words >= 200 && rx_words < 320) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 8);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      if (frame_scoreboard.size() == 0) begin
        $error("unexpected result word: tdata %h tuser %b tlast %b",
               m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        exp_w = frame_scoreboard.pop_front();
        words_checked++;
        if (m_tuser !== exp_w.kind) begin
          $error("kind: expected %0d, got %0d", exp_w.kind, m_tuser);
          errors++;
        end
        if (m_tdata[23:0] !== exp_w.tx_word) begin
          $error("tx_word: expected %h, got %h", exp_w.tx_word, m_tdata[23:0]);
          errors++;
        end
        if (m_tdata[25:24] !== exp_w.tx_bytes) begin
          $error("tx_bytes: expected %0d, got %0d", exp_w.tx_bytes, m_tdata[25:24]);
          errors++;
        end
        if (m_tdata[43:26] !== exp_w.read_data) begin
          $error("read_data: expected %h, got %h", exp_w.read_data, m_tdata[43:26]);
          errors++;
        end
        if (m_tdata[44] !== exp_w.dev_error) begin
          $error("dev_error: expected %0d, got %0d", exp_w.dev_error, m_tdata[44]);
          errors++;
        end
        if (m_tdata[45] !== exp_w.parity_error) begin
          $error("parity_error: expected %0d, got %0d", exp_w.parity_error, m_tdata[45]);
          errors++;
        end
        if (m_tlast !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no word moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    static int quiet = 0;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles with no word moving, %0d results outstanding",
                 quiet, frame_scoreboard.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(logic [1:0] act, logic [7:0] addr, logic [7:0] wd,
                           logic [23:0] rw, bit drain);
    cmd_item_t it;
    it = '{action: act, address: addr, write_data: wd, reply_word: rw, drain: drain};
    cmd_queue.push_back(it);
    cmds_total++;
  endtask

  initial begin
    int          n_random;
    int          roll;
    int          k;
    logic [7:0]  addr;

    // Directed: field extremes, both read widths, width kept across writes,
    // dropped code, narrow decode ignoring the upper byte.
    queue_cmd(ACT_READ,   8'h00, 8'h00, 24'h000000, 1'b0);
    queue_cmd(ACT_READ,   8'hff, 8'h00, 24'h000000, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'hffffff, 1'b0);
    queue_cmd(ACT_READ,   WIDE_ADDR, 8'h00, 24'h000000, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'hffffff, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'h000000, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'h400000, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'h00000f, 1'b0);
    queue_cmd(ACT_WRITE,  8'hff, 8'h00, 24'h000000, 1'b0);
    queue_cmd(ACT_WRITE,  8'h00, 8'hff, 24'hffffff, 1'b0);
    queue_cmd(ACT_REPLY,  8'hff, 8'hff, 24'h3ffff0, 1'b0);
    queue_cmd(ACT_UNUSED, 8'hff, 8'hff, 24'hffffff, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'h800001, 1'b0);
    queue_cmd(ACT_READ,   8'h3e, 8'hff, 24'hffffff, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'hffffff, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'h004000, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'h003fff, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'hff0001, 1'b0);
    queue_cmd(ACT_READ,   WIDE_ADDR, 8'h00, 24'h000000, 1'b0);
    queue_cmd(ACT_UNUSED, 8'h00, 8'h00, 24'h000000, 1'b0);
    queue_cmd(ACT_READ,   8'h40, 8'h00, 24'h000000, 1'b0);
    queue_cmd(ACT_WRITE,  WIDE_ADDR, UNLOCK_KEY, 24'h000000, 1'b0);
    queue_cmd(ACT_REPLY,  8'h00, 8'h00, 24'h123456, 1'b0);

    // Random: mostly read-then-reply sequences, writes, stray replies, and
    // a little noise on the unused code. The noise does not count.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        addr = ($urandom_range(3) == 0) ? WIDE_ADDR : 8'($urandom);
        queue_cmd(ACT_READ, addr, 8'($urandom), 24'($urandom),
                  n_random == DRAIN_ITEM);
        n_random++;
        k = $urandom_range(2, 1);
        repeat (k) begin
          queue_cmd(ACT_REPLY, 8'($urandom), 8'($urandom), 24'($urandom),
                    n_random == DRAIN_ITEM);
          n_random++;
        end
      end else if (roll < 75) begin
        queue_cmd(ACT_WRITE, 8'($urandom), 8'($urandom), 24'($urandom),
                  n_random == DRAIN_ITEM);
        n_random++;
      end else if (roll < 90) begin
        queue_cmd(ACT_REPLY, 8'($urandom), 8'($urandom), 24'($urandom),
                  n_random == DRAIN_ITEM);
        n_random++;
      end else begin
        queue_cmd(ACT_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom), 1'b0);
      end
    end

    // Hold reset, then release it once.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to be taken and every result to come back.
    while (cmds_sent < cmds_total) @(posedge clk);
    while (frame_scoreboard.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d request words: %0d reads (%0d wide), %0d writes, %0d replies,",
             cmds_sent, n_reads, n_wide_reads, n_writes, n_replies);
    $display("%0d dropped codes; %0d result words checked under random stalls and a hold-off",
             n_dropped, words_checked);
    if (errors == 0 && frame_scoreboard.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
